// File: hw/rtl/arsc_pkg.sv
// Shared types, codes and result builders for the article record stream checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package arsc_pkg;

	localparam int unsigned BYTE_BITS       = 8;
	localparam int unsigned SPAN_BODY_BYTES = 7;
	localparam int unsigned OUTQ_DEPTH      = 4;

	// Result kinds.
	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_SPAN  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Error codes.
	localparam logic [2:0] ERR_SHORT_HEADER = 3'd0;
	localparam logic [2:0] ERR_TEXT_TRUNC   = 3'd1;
	localparam logic [2:0] ERR_BAD_UTF8     = 3'd2;
	localparam logic [2:0] ERR_NO_SPAN_LEN  = 3'd3;
	localparam logic [2:0] ERR_SPAN_TRUNC   = 3'd4;
	localparam logic [2:0] ERR_SPAN_RANGE   = 3'd5;

	// Range that the next continuation byte must fall in.
	typedef enum logic [2:0] {
		CLIM_NORMAL = 3'd0,
		CLIM_E0     = 3'd1,
		CLIM_ED     = 3'd2,
		CLIM_F0     = 3'd3,
		CLIM_F4     = 3'd4
	} clim_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  error_code;
		logic [15:0] text_units;
		logic [15:0] span_begin;
		logic [15:0] span_size;
		logic [15:0] span_data_first;
		logic [15:0] span_data_second;
		logic [7:0]  span_kind;
		logic        last_of_run;
	} out_item_t;

	// Decoder verdict on one text byte.
	typedef struct packed {
		logic       ok;
		logic [1:0] pend_next;
		clim_t      clim_next;
		logic [1:0] unit_inc;
	} utf8_res_t;

	// Results produced by one request, in order.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	function automatic out_item_t res_text(input logic [15:0] units);
		out_item_t r;
		r = '0;
		r.result_kind = KIND_TEXT;
		r.text_units  = units;
		return r;
	endfunction

	function automatic out_item_t res_err(input logic [2:0] code);
		out_item_t r;
		r = '0;
		r.result_kind = KIND_ERROR;
		r.error_code  = code;
		return r;
	endfunction

	function automatic out_item_t res_end();
		out_item_t r;
		r = '0;
		r.result_kind = KIND_END;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/arsc_utf8.sv
// Strict UTF-8 byte check and UTF-16 unit increment for one text byte.
// Depends on arsc_pkg.
`default_nettype none

module arsc_utf8 (
	input  wire logic [7:0]      data_byte,
	input  wire logic [1:0]      pend,
	input  wire arsc_pkg::clim_t clim,
	output arsc_pkg::utf8_res_t res
);

	logic [7:0] lo;
	logic [7:0] hi;

	always_comb begin
		lo = 8'h80;
		hi = 8'hBF;
		case (clim)
			arsc_pkg::CLIM_E0: lo = 8'hA0;
			arsc_pkg::CLIM_ED: hi = 8'h9F;
			arsc_pkg::CLIM_F0: lo = 8'h90;
			arsc_pkg::CLIM_F4: hi = 8'h8F;
			default: begin
				lo = 8'h80;
				hi = 8'hBF;
			end
		endcase

		res.ok        = 1'b0;
		res.pend_next = pend;
		res.clim_next = clim;
		res.unit_inc  = 2'd0;

		if (pend != 2'd0) begin
			// A rejected continuation leaves the pending state untouched.
			if (data_byte >= lo && data_byte <= hi) begin
				res.ok        = 1'b1;
				res.pend_next = pend - 2'd1;
				res.clim_next = arsc_pkg::CLIM_NORMAL;
			end
		end else begin
			res.clim_next = arsc_pkg::CLIM_NORMAL;
			if (data_byte == 8'h00) begin
				res.ok = 1'b0;
			end else if (data_byte < 8'h80) begin
				res.ok       = 1'b1;
				res.unit_inc = 2'd1;
			end else if (data_byte < 8'hC2) begin
				res.ok = 1'b0;
			end else if (data_byte < 8'hE0) begin
				res.ok        = 1'b1;
				res.pend_next = 2'd1;
				res.unit_inc  = 2'd1;
			end else if (data_byte < 8'hF0) begin
				res.ok        = 1'b1;
				res.pend_next = 2'd2;
				res.unit_inc  = 2'd1;
				if (data_byte == 8'hE0) begin
					res.clim_next = arsc_pkg::CLIM_E0;
				end else if (data_byte == 8'hED) begin
					res.clim_next = arsc_pkg::CLIM_ED;
				end
			end else if (data_byte < 8'hF5) begin
				// Four-byte sequences lie above the BMP and need a surrogate pair.
				res.ok        = 1'b1;
				res.pend_next = 2'd3;
				res.unit_inc  = 2'd2;
				if (data_byte == 8'hF0) begin
					res.clim_next = arsc_pkg::CLIM_F0;
				end else if (data_byte == 8'hF4) begin
					res.clim_next = arsc_pkg::CLIM_F4;
				end
			end else begin
				res.ok = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/arsc_parser.sv
// Record parser: phase, counters and span fields, updated once per accepted byte.
// Depends on arsc_pkg and arsc_utf8; produces up to two results per request.
`default_nettype none

module arsc_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire arsc_pkg::in_item_t item,
	output arsc_pkg::push_t         push
);

	typedef enum logic [2:0] {
		PH_TLO  = 3'd0,
		PH_THI  = 3'd1,
		PH_TEXT = 3'd2,
		PH_TBAD = 3'd3,
		PH_SLO  = 3'd4,
		PH_SHI  = 3'd5,
		PH_BODY = 3'd6
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [15:0]         left_q, left_d;
	logic [15:0]         units_q, units_d;
	logic [1:0]          pend_q, pend_d;
	arsc_pkg::clim_t     clim_q, clim_d;
	logic [7:0]          hdr_q, hdr_d;
	logic [15:0]         size_q, size_d;
	logic [6:0][7:0]     fields_q, fields_d;
	logic                skip_q, skip_d;

	arsc_pkg::utf8_res_t u;
	arsc_pkg::push_t     p;

	arsc_utf8 u_utf8 (
		.data_byte (item.data_byte),
		.pend      (pend_q),
		.clim      (clim_q),
		.res       (u)
	);

	always_comb begin
		logic [15:0] word;
		logic [15:0] left_dec;
		logic [2:0]  idx;
		logic [16:0] reach;
		logic        bad;
		logic        e;

		phase_d  = phase_q;
		left_d   = left_q;
		units_d  = units_q;
		pend_d   = pend_q;
		clim_d   = clim_q;
		hdr_d    = hdr_q;
		size_d   = size_q;
		fields_d = fields_q;
		skip_d   = skip_q;
		p        = '0;

		e        = item.end_of_data;
		word     = {item.data_byte, hdr_q};
		left_dec = left_q - 16'd1;
		idx      = 3'(3'd7 - left_q[2:0]);
		reach    = '0;
		bad      = 1'b0;

		if (acc) begin
			if (skip_q) begin
				if (e) begin
					phase_d  = PH_TLO;
					left_d   = '0;
					units_d  = '0;
					pend_d   = '0;
					clim_d   = arsc_pkg::CLIM_NORMAL;
					hdr_d    = '0;
					size_d   = '0;
					fields_d = '0;
					skip_d   = 1'b0;
				end
			end else begin
				case (phase_q)
					PH_THI: begin
						left_d  = word;
						units_d = '0;
						pend_d  = '0;
						clim_d  = arsc_pkg::CLIM_NORMAL;
						if (word == 16'd0) begin
							p.count = 2'd1;
							p.first = arsc_pkg::res_text(16'd0);
							phase_d = PH_SLO;
							if (e) begin
								p.count  = 2'd2;
								p.second = arsc_pkg::res_err(arsc_pkg::ERR_NO_SPAN_LEN);
								phase_d  = PH_TLO;
							end
						end else if (e) begin
							p.count = 2'd1;
							p.first = arsc_pkg::res_err(arsc_pkg::ERR_TEXT_TRUNC);
							phase_d = PH_TLO;
						end else begin
							phase_d = PH_TEXT;
						end
					end
					PH_TEXT, PH_TBAD: begin
						bad = (phase_q == PH_TBAD);
						if (phase_q == PH_TEXT) begin
							units_d = units_q + 16'(u.unit_inc);
							pend_d  = u.pend_next;
							clim_d  = u.clim_next;
							bad     = !u.ok;
						end
						if (bad) begin
							phase_d = PH_TBAD;
						end
						left_d = left_dec;
						if (left_dec != 16'd0) begin
							if (e) begin
								p.count = 2'd1;
								p.first = arsc_pkg::res_err(arsc_pkg::ERR_TEXT_TRUNC);
								phase_d = PH_TLO;
							end
						end else if (bad || pend_d != 2'd0) begin
							p.count = 2'd1;
							p.first = arsc_pkg::res_err(arsc_pkg::ERR_BAD_UTF8);
							phase_d = PH_TLO;
							skip_d  = !e;
						end else begin
							p.count = 2'd1;
							p.first = arsc_pkg::res_text(units_d);
							phase_d = PH_SLO;
							if (e) begin
								p.count  = 2'd2;
								p.second = arsc_pkg::res_err(arsc_pkg::ERR_NO_SPAN_LEN);
								phase_d  = PH_TLO;
							end
						end
					end
					PH_SLO: begin
						hdr_d = item.data_byte;
						if (e) begin
							p.count = 2'd1;
							p.first = arsc_pkg::res_err(arsc_pkg::ERR_NO_SPAN_LEN);
							phase_d = PH_TLO;
						end else begin
							phase_d = PH_SHI;
						end
					end
					PH_SHI: begin
						if (word == 16'd0) begin
							// Record terminator: start the next record, reporting a clean end if the data ends here.
							phase_d = PH_TLO;
							if (e) begin
								p.count = 2'd1;
								p.first = arsc_pkg::res_end();
							end
						end else if (e) begin
							size_d  = word;
							p.count = 2'd1;
							p.first = arsc_pkg::res_err(arsc_pkg::ERR_SPAN_TRUNC);
							phase_d = PH_TLO;
						end else begin
							size_d   = word;
							fields_d = '0;
							left_d   = 16'(arsc_pkg::SPAN_BODY_BYTES);
							phase_d  = PH_BODY;
						end
					end
					PH_BODY: begin
						if (idx != 3'd7) begin
							fields_d[idx] = fields_q[idx] | item.data_byte;
						end
						left_d = left_dec;
						if (left_dec != 16'd0 &&
						    left_dec <= 16'(arsc_pkg::SPAN_BODY_BYTES)) begin
							if (e) begin
								p.count = 2'd1;
								p.first = arsc_pkg::res_err(arsc_pkg::ERR_SPAN_TRUNC);
								phase_d = PH_TLO;
							end
						end else begin
							left_d = '0;
							reach  = {1'b0, fields_d[1], fields_d[0]} + {1'b0, size_q};
							if (reach > {1'b0, units_q}) begin
								p.count = 2'd1;
								p.first = arsc_pkg::res_err(arsc_pkg::ERR_SPAN_RANGE);
								phase_d = PH_TLO;
								skip_d  = !e;
							end else begin
								p.count                  = 2'd1;
								p.first.result_kind      = arsc_pkg::KIND_SPAN;
								p.first.span_begin       = {fields_d[1], fields_d[0]};
								p.first.span_size        = size_q;
								p.first.span_data_first  = {fields_d[3], fields_d[2]};
								p.first.span_data_second = {fields_d[5], fields_d[4]};
								p.first.span_kind        = fields_d[6];
								phase_d                  = PH_SLO;
								if (e) begin
									p.count  = 2'd2;
									p.second = arsc_pkg::res_err(arsc_pkg::ERR_NO_SPAN_LEN);
									phase_d  = PH_TLO;
								end
							end
						end
					end
					default: begin
						hdr_d = item.data_byte;
						if (e) begin
							p.count = 2'd1;
							p.first = arsc_pkg::res_err(arsc_pkg::ERR_SHORT_HEADER);
							phase_d = PH_TLO;
						end else begin
							phase_d = PH_THI;
						end
					end
				endcase
			end
		end

		if (p.count == 2'd1) begin
			p.first.last_of_run = 1'b1;
		end
		if (p.count == 2'd2) begin
			p.second.last_of_run = 1'b1;
		end
	end

	assign push = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TLO;
			left_q   <= '0;
			units_q  <= '0;
			pend_q   <= '0;
			clim_q   <= arsc_pkg::CLIM_NORMAL;
			hdr_q    <= '0;
			size_q   <= '0;
			fields_q <= '0;
			skip_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			units_q  <= units_d;
			pend_q   <= pend_d;
			clim_q   <= clim_d;
			hdr_q    <= hdr_d;
			size_q   <= size_d;
			fields_q <= fields_d;
			skip_q   <= skip_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/arsc_outq.sv
// Result queue: takes up to two results per request, hands out one per cycle while out_ready is high.
// Depends on arsc_pkg.
`default_nettype none

module arsc_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire arsc_pkg::push_t     push,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output arsc_pkg::out_item_t      out_item
);

	localparam int unsigned PW = $clog2(arsc_pkg::OUTQ_DEPTH);
	localparam int unsigned CW = $clog2(arsc_pkg::OUTQ_DEPTH + 1);

	arsc_pkg::out_item_t  mem_q [arsc_pkg::OUTQ_DEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [CW-1:0]        cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// Room for a request's worst case of two results.
	assign room      = (cnt_q <= CW'(arsc_pkg::OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[PW'(wr_q + PW'(1))] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PW'(wr_q + PW'(push.count));
			rd_q  <= PW'(rd_q + PW'(pop));
			cnt_q <= CW'(cnt_q + CW'(push.count) - CW'(pop));
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/article_record_stream_checker.sv
// Article record stream checker, top level. A byte is taken in every cycle while
// the result queue has room for two results; its results are written into the
// queue and handed out in order, one per cycle while out_ready is high. Asynchronous
// active-low reset returns the parser to the start of an article and empties the
// result queue.
// Depends on arsc_pkg, arsc_parser and arsc_outq.
`default_nettype none

module article_record_stream_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire arsc_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output arsc_pkg::out_item_t      out_item
);

	arsc_pkg::push_t push;
	logic            acc;

	assign acc = in_valid && in_ready;

	arsc_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (in_item),
		.push   (push)
	);

	arsc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// File: hw/rtl/arsc_checker.sv
// Port-level checks for the article record stream checker, and their binding.
// Depends on arsc_pkg and article_record_stream_checker.
`default_nettype none

module arsc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire arsc_pkg::out_item_t out_item
);

	// No result may be on offer once reset has been seen at a clock edge.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result offered during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// Errors carry a known code and no payload.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind == arsc_pkg::KIND_ERROR |->
			out_item.error_code <= arsc_pkg::ERR_SPAN_RANGE &&
			out_item.text_units == 16'd0 && out_item.span_begin == 16'd0 &&
			out_item.span_size == 16'd0 && out_item.span_kind == 8'd0)
		else $error("malformed error result");

	a_span_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind == arsc_pkg::KIND_SPAN |->
			out_item.span_size != 16'd0 && out_item.error_code == 3'd0)
		else $error("span result with zero size or error code");

	// A clean end is always the only result of its byte.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind == arsc_pkg::KIND_END |->
			out_item.last_of_run)
		else $error("clean end not last of its run");

endmodule

bind article_record_stream_checker arsc_checker u_arsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

`default_nettype wire

// File: tb/sv/article_record_stream_checker_tb.sv
// Self-checking testbench for the article record stream checker: drives byte requests
// and compares every result with the typed-in results or a built-in model of the record parser.
// Depends on arsc_pkg and article_record_stream_checker.
module article_record_stream_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arsc_pkg::*;

	localparam int RANDOM_BYTES = 1900;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		LEN_LO,
		LEN_HI,
		TEXT_OK,
		TEXT_BAD,
		SPAN_LO,
		SPAN_HI,
		SPAN_BODY
	} parse_phase_t;

	// One byte request, with its results typed in where they are obvious.
	typedef struct packed {
		in_item_t   item;
		logic       typed;
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      out_ready = 1'b0;
	in_item_t  in_item   = '0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	stim_row_t article_bytes[$];
	out_item_t awaited_results[$];
	out_item_t step_results[$];
	logic [7:0] draft[$];

	int accepted     = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int send_pct     = 0;
	int recv_pct     = 0;
	int n_directed;

	// Parser state of the model.
	parse_phase_t ph;
	logic [15:0]  bytes_to_go;
	logic [15:0]  utf16_units;
	logic [1:0]   conts_due;
	clim_t        cont_bounds;
	logic [7:0]   len_low;
	logic [15:0]  span_len;
	logic [55:0]  span_fields;
	logic         skip_to_end;

	article_record_stream_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #2 clk = ~clk;

	function automatic out_item_t make_result(input logic [1:0] kind, input logic [2:0] code,
			input logic [15:0] units, input logic [15:0] sbeg, input logic [15:0] ssize,
			input logic [15:0] d1, input logic [15:0] d2, input logic [7:0] skind);
		out_item_t r;
		r = '0;
		r.result_kind      = kind;
		r.error_code       = code;
		r.text_units       = units;
		r.span_begin       = sbeg;
		r.span_size        = ssize;
		r.span_data_first  = d1;
		r.span_data_second = d2;
		r.span_kind        = skind;
		return r;
	endfunction

	function automatic void parser_reset();
		ph          = LEN_LO;
		bytes_to_go = '0;
		utf16_units = '0;
		conts_due   = '0;
		cont_bounds = CLIM_NORMAL;
		len_low     = '0;
		span_len    = '0;
		span_fields = '0;
		skip_to_end = 1'b0;
	endfunction

	// An error on a byte that is not the last one leaves the parser skipping to the end.
	function automatic out_item_t reject(input logic [2:0] code, input logic at_end);
		ph          = LEN_LO;
		skip_to_end = !at_end;
		return make_result(KIND_ERROR, code, '0, '0, '0, '0, '0, '0);
	endfunction

	function automatic logic utf8_accept(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (conts_due != 2'd0) begin
			case (cont_bounds)
			CLIM_E0: lo = 8'hA0;
			CLIM_ED: hi = 8'h9F;
			CLIM_F0: lo = 8'h90;
			CLIM_F4: hi = 8'h8F;
			default: ;
			endcase
			if (b < lo || b > hi)
				return 1'b0;
			conts_due   = conts_due - 2'd1;
			cont_bounds = CLIM_NORMAL;
			return 1'b1;
		end
		cont_bounds = CLIM_NORMAL;
		if (b == 8'h00)
			return 1'b0;
		if (b < 8'h80) begin
			utf16_units = utf16_units + 16'd1;
			return 1'b1;
		end
		if (b < 8'hC2)
			return 1'b0;
		if (b < 8'hE0) begin
			conts_due = 2'd1;
		end else if (b < 8'hF0) begin
			conts_due = 2'd2;
			if (b == 8'hE0)
				cont_bounds = CLIM_E0;
			else if (b == 8'hED)
				cont_bounds = CLIM_ED;
		end else if (b < 8'hF5) begin
			conts_due = 2'd3;
			if (b == 8'hF0)
				cont_bounds = CLIM_F0;
			else if (b == 8'hF4)
				cont_bounds = CLIM_F4;
			// Four-byte sequences need a surrogate pair.
			utf16_units = utf16_units + 16'd1;
		end else begin
			return 1'b0;
		end
		utf16_units = utf16_units + 16'd1;
		return 1'b1;
	endfunction

	// Advances the model by one byte and leaves its results in step_results.
	function automatic void predict_byte(input in_item_t it);
		logic [7:0]  b;
		logic        eod;
		logic [15:0] hdr;
		logic [2:0]  pos;
		logic [16:0] reach;
		b   = it.data_byte;
		eod = it.end_of_data;
		step_results.delete();
		if (skip_to_end) begin
			if (eod)
				parser_reset();
			return;
		end
		case (ph)
		LEN_HI: begin
			hdr         = {b, len_low};
			bytes_to_go = hdr;
			utf16_units = '0;
			conts_due   = '0;
			cont_bounds = CLIM_NORMAL;
			if (hdr == 16'd0) begin
				step_results.push_back(make_result(KIND_TEXT, '0, '0, '0, '0, '0, '0, '0));
				ph = SPAN_LO;
				if (eod)
					step_results.push_back(reject(ERR_NO_SPAN_LEN, 1'b1));
			end else if (eod) begin
				step_results.push_back(reject(ERR_TEXT_TRUNC, 1'b1));
			end else begin
				ph = TEXT_OK;
			end
		end
		TEXT_OK, TEXT_BAD: begin
			// Once the text is bad its bytes are still counted off.
			if (ph == TEXT_OK && !utf8_accept(b))
				ph = TEXT_BAD;
			bytes_to_go = bytes_to_go - 16'd1;
			if (bytes_to_go != 16'd0) begin
				if (eod)
					step_results.push_back(reject(ERR_TEXT_TRUNC, 1'b1));
			end else if (ph == TEXT_BAD || conts_due != 2'd0) begin
				step_results.push_back(reject(ERR_BAD_UTF8, eod));
			end else begin
				step_results.push_back(make_result(KIND_TEXT, '0, utf16_units,
					'0, '0, '0, '0, '0));
				ph = SPAN_LO;
				if (eod)
					step_results.push_back(reject(ERR_NO_SPAN_LEN, 1'b1));
			end
		end
		SPAN_LO: begin
			len_low = b;
			if (eod)
				step_results.push_back(reject(ERR_NO_SPAN_LEN, 1'b1));
			else
				ph = SPAN_HI;
		end
		SPAN_HI: begin
			hdr = {b, len_low};
			if (hdr == 16'd0) begin
				ph = LEN_LO;
				if (eod)
					step_results.push_back(make_result(KIND_END, '0, '0, '0, '0, '0, '0, '0));
			end else begin
				span_len = hdr;
				if (eod) begin
					step_results.push_back(reject(ERR_SPAN_TRUNC, 1'b1));
				end else begin
					span_fields = '0;
					bytes_to_go = 16'(SPAN_BODY_BYTES);
					ph          = SPAN_BODY;
				end
			end
		end
		SPAN_BODY: begin
			pos = 3'(SPAN_BODY_BYTES - bytes_to_go);
			span_fields[pos*8 +: 8] = b;
			bytes_to_go = bytes_to_go - 16'd1;
			if (bytes_to_go != 16'd0) begin
				if (eod)
					step_results.push_back(reject(ERR_SPAN_TRUNC, 1'b1));
			end else begin
				reach = 17'(span_fields[15:0]) + 17'(span_len);
				if (reach > 17'(utf16_units)) begin
					step_results.push_back(reject(ERR_SPAN_RANGE, eod));
				end else begin
					step_results.push_back(make_result(KIND_SPAN, '0, '0, span_fields[15:0],
						span_len, span_fields[31:16], span_fields[47:32], span_fields[55:48]));
					ph = SPAN_LO;
					if (eod)
						step_results.push_back(reject(ERR_NO_SPAN_LEN, 1'b1));
				end
			end
		end
		default: begin
			len_low = b;
			if (eod)
				step_results.push_back(reject(ERR_SHORT_HEADER, 1'b1));
			else
				ph = LEN_HI;
		end
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic eod);
		stim_row_t row;
		row = '0;
		row.item.data_byte   = b;
		row.item.end_of_data = eod;
		article_bytes.push_back(row);
	endfunction

	function automatic void add_typed(input logic [7:0] b, input logic eod,
			input logic [1:0] cnt, input out_item_t first, input out_item_t second);
		stim_row_t row;
		row = '0;
		row.item.data_byte   = b;
		row.item.end_of_data = eod;
		row.typed  = 1'b1;
		row.count  = cnt;
		row.first  = first;
		row.second = second;
		if (cnt == 2'd1)
			row.first.last_of_run = 1'b1;
		if (cnt == 2'd2)
			row.second.last_of_run = 1'b1;
		article_bytes.push_back(row);
	endfunction

	function automatic void push16(input logic [15:0] v);
		draft.push_back(v[7:0]);
		draft.push_back(v[15:8]);
	endfunction

	function automatic void push_cont(input logic [7:0] lo, input logic [7:0] hi);
		draft.push_back(8'($urandom_range(lo, hi)));
	endfunction

	// Appends one character to the draft and returns its UTF-16 length. A sloppy
	// character may be any byte at all.
	function automatic int append_char(input logic sloppy);
		logic [7:0] lead;
		int units;
		units = 1;
		case ($urandom_range(0, sloppy ? 5 : 4))
		0, 4: draft.push_back(8'($urandom_range(1, 127)));
		1: begin
			draft.push_back(8'($urandom_range(8'hC2, 8'hDF)));
			push_cont(8'h80, 8'hBF);
		end
		2: begin
			lead = 8'($urandom_range(8'hE0, 8'hEF));
			draft.push_back(lead);
			if (lead == 8'hE0)
				push_cont(8'hA0, 8'hBF);
			else if (lead == 8'hED)
				push_cont(8'h80, 8'h9F);
			else
				push_cont(8'h80, 8'hBF);
			push_cont(8'h80, 8'hBF);
		end
		3: begin
			lead = 8'($urandom_range(8'hF0, 8'hF4));
			draft.push_back(lead);
			if (lead == 8'hF0)
				push_cont(8'h90, 8'hBF);
			else if (lead == 8'hF4)
				push_cont(8'h80, 8'h8F);
			else
				push_cont(8'h80, 8'hBF);
			push_cont(8'h80, 8'hBF);
			push_cont(8'h80, 8'hBF);
			units = 2;
		end
		default: begin
			draft.push_back(8'($urandom));
			units = 0;
		end
		endcase
		return units;
	endfunction

	// Most articles are well formed; some are cut short or have a byte overwritten,
	// and a few are plain noise.
	function automatic void add_article();
		int style;
		int len_at;
		int text_len;
		int units;
		int cut;
		logic [15:0] sbeg;
		logic [15:0] ssize;
		draft.delete();
		style = $urandom_range(0, 99);
		if (style >= 88) begin
			repeat ($urandom_range(1, 12))
				draft.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) begin
				len_at = draft.size();
				push16(16'h0000);
				units = 0;
				repeat ($urandom_range(0, 6))
					units += append_char(style >= 70);
				text_len = draft.size() - len_at - 2;
				draft[len_at]     = 8'(text_len);
				draft[len_at + 1] = 8'(text_len >> 8);
				repeat ($urandom_range(0, 3)) begin
					if (units == 0 || $urandom_range(0, 5) == 0) begin
						ssize = 16'($urandom_range(1, 65535));
						sbeg  = 16'($urandom);
					end else begin
						ssize = 16'($urandom_range(1, units));
						sbeg  = 16'($urandom_range(0, units - ssize));
					end
					push16(ssize);
					push16(sbeg);
					push16(16'($urandom));
					push16(16'($urandom));
					draft.push_back(8'($urandom));
				end
				push16(16'h0000);
			end
			if (style >= 70) begin
				if ($urandom_range(0, 1) == 1)
					draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom);
				if ($urandom_range(0, 2) != 0) begin
					cut = $urandom_range(1, draft.size());
					while (draft.size() > cut)
						void'(draft.pop_back());
				end
			end
		end
		foreach (draft[k])
			add_byte(draft[k], k == draft.size() - 1);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp,
			input logic [15:0] got);
		if (got !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, got);
			mismatches++;
		end
	endfunction

	// The receiver stalls at random; the rate is set by the phase of the run.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_pct);

	always @(posedge clk) begin
		stim_row_t row;
		out_item_t exp;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				row = article_bytes[accepted];
				accepted++;
				predict_byte(row.item);
				if (row.typed) begin
					if (row.count >= 2'd1)
						awaited_results.push_back(row.first);
					if (row.count == 2'd2)
						awaited_results.push_back(row.second);
				end else begin
					foreach (step_results[k]) begin
						exp = step_results[k];
						exp.last_of_run = (k == step_results.size() - 1);
						awaited_results.push_back(exp);
					end
				end
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0d, error code %0d",
						out_item.result_kind, out_item.error_code);
					mismatches++;
				end else begin
					exp = awaited_results.pop_front();
					check_field("result_kind", exp.result_kind, out_item.result_kind);
					check_field("error_code", exp.error_code, out_item.error_code);
					check_field("text_units", exp.text_units, out_item.text_units);
					check_field("span_begin", exp.span_begin, out_item.span_begin);
					check_field("span_size", exp.span_size, out_item.span_size);
					check_field("span_data_first", exp.span_data_first,
						out_item.span_data_first);
					check_field("span_data_second", exp.span_data_second,
						out_item.span_data_second);
					check_field("span_kind", exp.span_kind, out_item.span_kind);
					check_field("last_of_run", exp.last_of_run, out_item.last_of_run);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		int phase_no;
		parser_reset();

		// A lone byte that ends the article leaves the length header short.
		add_typed(8'hFF, 1'b1, 2'd1,
			make_result(KIND_ERROR, ERR_SHORT_HEADER, '0, '0, '0, '0, '0, '0), '0);
		// Empty text reported on its length, then the data ends with no span length.
		add_byte(8'h00, 1'b0);
		add_typed(8'h00, 1'b1, 2'd2, make_result(KIND_TEXT, '0, '0, '0, '0, '0, '0, '0),
			make_result(KIND_ERROR, ERR_NO_SPAN_LEN, '0, '0, '0, '0, '0, '0));
		// Seven bytes of text: U+0800 at the bottom of its range and U+10FFFF at the top.
		add_byte(8'h07, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hE0, 1'b0);
		add_byte(8'hA0, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hF4, 1'b0);
		add_byte(8'h8F, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_typed(8'hBF, 1'b0, 2'd1,
			make_result(KIND_TEXT, '0, 16'd3, '0, '0, '0, '0, '0), '0);
		// A span that covers the whole text exactly.
		add_byte(8'h03, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_typed(8'hFF, 1'b0, 2'd1, make_result(KIND_SPAN, '0, '0, 16'd0, 16'd3,
			16'hFFFF, 16'h0000, 8'hFF), '0);
		add_byte(8'h00, 1'b0);
		add_typed(8'h00, 1'b1, 2'd1,
			make_result(KIND_END, '0, '0, '0, '0, '0, '0, '0), '0);
		// A NUL byte is not allowed in the text.
		add_byte(8'h01, 1'b0);
		add_byte(8'h00, 1'b0);
		add_typed(8'h00, 1'b1, 2'd1,
			make_result(KIND_ERROR, ERR_BAD_UTF8, '0, '0, '0, '0, '0, '0), '0);

		n_directed = article_bytes.size();
		while (article_bytes.size() < n_directed + RANDOM_BYTES)
			add_article();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < article_bytes.size(); i++) begin
			// The random part runs in four phases of back-pressure.
			if (i >= n_directed) begin
				phase_no = (i - n_directed) * 4 / (article_bytes.size() - n_directed);
				case (phase_no)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 76; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 76; end
				default: begin send_pct = 16; recv_pct = 16; end
				endcase
			end
			gap = 0;
			while ($urandom_range(0, 99) < send_pct)
				gap++;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid <= 1'b1;
			in_item  <= article_bytes[i].item;
			do
				@(posedge clk);
			while (!in_ready);
			@(negedge clk);
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
